@@ design/dmsc_pkg.sv @@
// Package for the dual motor speed controller: mode codes, frame opcodes,
// field widths and the packed layouts of the stream items.
// Used by dual_motor_speed_controller; depends on nothing else.
package dmsc_pkg;

	// Field widths fixed by the stream formats.
	localparam int FRAME_BYTE_W = 8;
	localparam int ENC_W        = 16;
	localparam int GAIN_W       = 16;
	localparam int DUTY_W       = 13;
	localparam int ERR_W        = 23;
	localparam int DIFF_W       = ERR_W + 1;
	localparam int PROD_P_W     = GAIN_W + ERR_W;
	localparam int PROD_D_W     = GAIN_W + DIFF_W;
	localparam int ACC_W        = PROD_D_W + 2;

	// Default full-scale duty and the fixed drive used while turning.
	localparam int PWM_MAX_DEF = 7199;
	localparam logic [DUTY_W-1:0] TURN_DRIVE = 13'd7100;

	// Configuration register indexes.
	localparam logic REG_PGAIN = 1'b0;
	localparam logic REG_DGAIN = 1'b1;

	// Command frame opcodes (byte 0).
	localparam logic signed [FRAME_BYTE_W-1:0] OP_SPEED     = 8'sd0;
	localparam logic signed [FRAME_BYTE_W-1:0] OP_SPEED_ALT = 8'sd1;
	localparam logic signed [FRAME_BYTE_W-1:0] OP_HALT      = 8'sd2;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_SPEED = 2'd1,
		MODE_TURN  = 2'd2,
		MODE_HALT  = 2'd3
	} mode_t;

	// Input tdata layout, last field in the lowest bits.
	typedef struct packed {
		logic signed [ENC_W-1:0]        enc_count_b;
		logic signed [ENC_W-1:0]        enc_count_a;
		logic signed [FRAME_BYTE_W-1:0] frame_angle;
		logic signed [FRAME_BYTE_W-1:0] frame_speed_b;
		logic signed [FRAME_BYTE_W-1:0] frame_speed_a;
		logic signed [FRAME_BYTE_W-1:0] frame_op;
	} tick_data_t;

	// Output tdata layout, padded to whole bytes.
	typedef struct packed {
		logic [1:0]        pad;
		mode_t             mode_now;
		logic              dir_b;
		logic [DUTY_W-1:0] pwm_b;
		logic              dir_a;
		logic [DUTY_W-1:0] pwm_a;
	} result_t;

	// What the product stage hands to the accumulate stage.
	typedef struct packed {
		mode_t                       mode;
		logic                        turn_negative;
		logic signed [PROD_P_W-1:0]  prod_p_a;
		logic signed [PROD_D_W-1:0]  prod_d_a;
		logic signed [PROD_P_W-1:0]  prod_p_b;
		logic signed [PROD_D_W-1:0]  prod_d_b;
	} pi_stage_t;

endpackage

@@ design/dual_motor_speed_controller.sv @@
// Dual motor speed controller top level: frame decode, incremental PI loop
// per motor and duty/direction encoding. Depends on dmsc_pkg.
//
// The block takes one control tick per stream transaction: two encoder counts
// plus an optional command frame flagged by s_tuser. A valid frame selects the
// mode (speed loop with new targets, halt, or turn with direction from the sign
// of the angle byte); an unknown opcode with a zero angle acts as a speed frame
// with both targets zero. In speed mode each motor runs an incremental PI step,
// error = target - 50*count, and the drive is clamped to 0..PWM_MAX. Each tick
// produces exactly one result transaction holding the duty and direction of
// both channels and the mode after the tick; channel A is driven from motor B
// and channel B from motor A. The datapath is three register stages (input,
// error and gain products, accumulate and encode), and a new tick can be
// accepted every cycle. The products are formed before the drive loop, so the
// only feedback inside a cycle is the drive add and clamp, which is what allows
// one tick per cycle. A stalled output fills the stages behind it before
// s_tready drops. The gains are written over the APB port at byte addresses 0
// (proportional) and 4 (difference) and should only change while no tick is in
// flight.

module dual_motor_speed_controller #(
	parameter int PWM_MAX = dmsc_pkg::PWM_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Tick input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata, lowest bit up: frame_op[7:0], frame_speed_a[15:8],
	// frame_speed_b[23:16], frame_angle[31:24], enc_count_a[47:32],
	// enc_count_b[63:48]
	input  logic [63:0] s_tdata,
	// s_tuser: frame_valid
	input  logic        s_tuser,
	// Result output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata, lowest bit up: pwm_a[12:0], dir_a[13], pwm_b[26:14], dir_b[27],
	// mode_now[29:28], zero padding [31:30]
	output logic [31:0] m_tdata
);
	import dmsc_pkg::*;

	localparam int DRIVE_W = $clog2(PWM_MAX + 1);
	localparam logic [31:0] PWM_MAX_32 = 32'(PWM_MAX);
	localparam logic [DUTY_W-1:0] DUTY_FULL = PWM_MAX_32[DUTY_W-1:0];

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [GAIN_W-1:0] pgain_q;
	logic signed [GAIN_W-1:0] dgain_q;
	logic cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pgain_q <= '0;
			dgain_q <= '0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_PGAIN: pgain_q <= pwdata[GAIN_W-1:0];
				REG_DGAIN: dgain_q <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PGAIN: prdata = 32'(pgain_q);
			REG_DGAIN: prdata = 32'(dgain_q);
			default:   prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Stage handshakes: each stage moves when the one after it has room.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s2, ready_s3;
	logic move_s1, move_s2, move_s3;

	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign s_tready = !valid_s1 || ready_s2;

	assign move_s1 = s_tvalid && s_tready;
	assign move_s2 = valid_s1 && ready_s2;
	assign move_s3 = valid_s2 && ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	tick_data_t tick_s1;
	logic       frame_valid_s1;

	always_ff @(posedge clk) begin
		if (move_s1) begin
			tick_s1        <= tick_data_t'(s_tdata);
			frame_valid_s1 <= s_tuser;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: frame decode, speed errors and gain products
	// ------------------------------------------------------------------
	mode_t                         mode_q;
	logic signed [FRAME_BYTE_W-1:0] ref_a_q, ref_b_q;
	logic                          turn_neg_q;
	logic signed [ERR_W-1:0]       last_err_a_q, last_err_b_q;

	mode_t                          mode_nxt;
	logic signed [FRAME_BYTE_W-1:0] ref_a_nxt, ref_b_nxt;
	logic                           turn_neg_nxt;
	logic signed [ERR_W-1:0]        count_a, count_b;
	logic signed [ERR_W-1:0]        err_a, err_b;
	logic signed [DIFF_W-1:0]       diff_a, diff_b;
	pi_stage_t                      pi_nxt;
	pi_stage_t                      pi_s2;

	always_comb begin
		mode_nxt     = mode_q;
		ref_a_nxt    = ref_a_q;
		ref_b_nxt    = ref_b_q;
		turn_neg_nxt = turn_neg_q;
		if (frame_valid_s1) begin
			if (tick_s1.frame_angle != '0) begin
				turn_neg_nxt = tick_s1.frame_angle[FRAME_BYTE_W-1];
				mode_nxt     = MODE_TURN;
			end else begin
				unique case (tick_s1.frame_op) inside
					OP_SPEED, OP_SPEED_ALT: begin
						ref_a_nxt = tick_s1.frame_speed_a;
						ref_b_nxt = tick_s1.frame_speed_b;
						mode_nxt  = MODE_SPEED;
					end
					OP_HALT: begin
						mode_nxt = MODE_HALT;
					end
					default: begin
						// Unknown opcode: speed loop with both targets at rest.
						ref_a_nxt = '0;
						ref_b_nxt = '0;
						mode_nxt  = MODE_SPEED;
					end
				endcase
			end
		end
	end

	// error = target - 50*count, with 50*count built from three shifts.
	always_comb begin
		count_a = ERR_W'(tick_s1.enc_count_a);
		count_b = ERR_W'(tick_s1.enc_count_b);
		err_a   = ERR_W'(ref_a_nxt) -
			((count_a <<< 5) + (count_a <<< 4) + (count_a <<< 1));
		err_b   = ERR_W'(ref_b_nxt) -
			((count_b <<< 5) + (count_b <<< 4) + (count_b <<< 1));
		diff_a  = DIFF_W'(err_a) - DIFF_W'(last_err_a_q);
		diff_b  = DIFF_W'(err_b) - DIFF_W'(last_err_b_q);
	end

	always_comb begin
		pi_nxt.mode          = mode_nxt;
		pi_nxt.turn_negative = turn_neg_nxt;
		pi_nxt.prod_p_a      = pgain_q * err_a;
		pi_nxt.prod_d_a      = dgain_q * diff_a;
		pi_nxt.prod_p_b      = pgain_q * err_b;
		pi_nxt.prod_d_b      = dgain_q * diff_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			ref_a_q      <= '0;
			ref_b_q      <= '0;
			turn_neg_q   <= 1'b0;
			last_err_a_q <= '0;
			last_err_b_q <= '0;
		end else if (move_s2) begin
			mode_q     <= mode_nxt;
			ref_a_q    <= ref_a_nxt;
			ref_b_q    <= ref_b_nxt;
			turn_neg_q <= turn_neg_nxt;
			// The error history only advances on ticks that run the loop.
			if (mode_nxt == MODE_SPEED) begin
				last_err_a_q <= err_a;
				last_err_b_q <= err_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) pi_s2 <= pi_nxt;
	end

	// ------------------------------------------------------------------
	// Stage 3: drive accumulate, clamp and channel encoding
	// ------------------------------------------------------------------
	logic [DRIVE_W-1:0]       drive_a_q, drive_b_q;
	logic signed [ACC_W-1:0]  acc_a, acc_b;
	logic [DRIVE_W-1:0]       drive_a_nxt, drive_b_nxt;
	logic [31:0]              drive_a_wide, drive_b_wide;
	result_t                  result_nxt;
	result_t                  result_s3;

	always_comb begin
		acc_a = ACC_W'($signed({1'b0, drive_a_q})) + ACC_W'(pi_s2.prod_p_a) +
			ACC_W'(pi_s2.prod_d_a);
		acc_b = ACC_W'($signed({1'b0, drive_b_q})) + ACC_W'(pi_s2.prod_p_b) +
			ACC_W'(pi_s2.prod_d_b);

		if (acc_a > $signed(ACC_W'(PWM_MAX)))  drive_a_nxt = DRIVE_W'(PWM_MAX);
		else if (acc_a < 0)                     drive_a_nxt = '0;
		else                                    drive_a_nxt = acc_a[DRIVE_W-1:0];

		if (acc_b > $signed(ACC_W'(PWM_MAX)))  drive_b_nxt = DRIVE_W'(PWM_MAX);
		else if (acc_b < 0)                     drive_b_nxt = '0;
		else                                    drive_b_nxt = acc_b[DRIVE_W-1:0];

		drive_a_wide = 32'(drive_a_nxt);
		drive_b_wide = 32'(drive_b_nxt);
	end

	// A positive motor value drives with dir low, zero means full duty with dir
	// high, and a negative value means dir high with zero duty.
	always_comb begin
		result_nxt          = '0;
		result_nxt.mode_now = pi_s2.mode;
		unique case (pi_s2.mode)
			MODE_SPEED: begin
				// Channel A follows motor B, channel B follows motor A.
				result_nxt.dir_a = (drive_b_nxt == '0);
				result_nxt.pwm_a = (drive_b_nxt == '0) ? DUTY_FULL :
					drive_b_wide[DUTY_W-1:0];
				result_nxt.dir_b = (drive_a_nxt == '0);
				result_nxt.pwm_b = (drive_a_nxt == '0) ? DUTY_FULL :
					drive_a_wide[DUTY_W-1:0];
			end
			MODE_TURN: begin
				if (!pi_s2.turn_negative) begin
					// Motor A reversed, motor B at turn drive.
					result_nxt.dir_a = 1'b0;
					result_nxt.pwm_a = TURN_DRIVE;
					result_nxt.dir_b = 1'b1;
					result_nxt.pwm_b = '0;
				end else begin
					result_nxt.dir_a = 1'b1;
					result_nxt.pwm_a = '0;
					result_nxt.dir_b = 1'b0;
					result_nxt.pwm_b = TURN_DRIVE;
				end
			end
			MODE_HALT: begin
				result_nxt.dir_a = 1'b1;
				result_nxt.pwm_a = '0;
				result_nxt.dir_b = 1'b1;
				result_nxt.pwm_b = '0;
			end
			default: begin
				// Idle: both motors at zero.
				result_nxt.dir_a = 1'b1;
				result_nxt.pwm_a = DUTY_FULL;
				result_nxt.dir_b = 1'b1;
				result_nxt.pwm_b = DUTY_FULL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_a_q <= '0;
			drive_b_q <= '0;
		end else if (move_s3 && pi_s2.mode == MODE_SPEED) begin
			drive_a_q <= drive_a_nxt;
			drive_b_q <= drive_b_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s3) result_s3 <= result_nxt;
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = result_s3;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_drive_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(drive_a_q) <= PWM_MAX_32) && (32'(drive_b_q) <= PWM_MAX_32))
		else $error("drive state exceeds full-scale duty");

	a_halt_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_s3.mode_now == MODE_HALT) |->
		(result_s3.dir_a && result_s3.dir_b &&
		 result_s3.pwm_a == '0 && result_s3.pwm_b == '0))
		else $error("halt result does not brake both channels");

	a_turn_opposed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_s3.mode_now == MODE_TURN) |->
		(result_s3.dir_a != result_s3.dir_b))
		else $error("turn result drives both channels the same way");

	a_history_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s2 && mode_nxt != MODE_SPEED) |=>
		($stable(last_err_a_q) && $stable(last_err_b_q)))
		else $error("error history changed outside the speed loop");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for dual_motor_speed_controller: a directed table of ticks,
// then random ticks under several gain settings, checked against a local model
// of the PI loop or typed-in results. Depends on dmsc_pkg and the controller RTL.
module tb_top;
	import dmsc_pkg::*;

	localparam int DUTY_FULL   = PWM_MAX_DEF;
	localparam int ERROR_SCALE = 50;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 16;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_TICKS = 50;
	localparam int MAX_REPORTS = 10;

	// One row of the directed table; fixed marks a row with a typed-in result.
	typedef struct packed {
		logic       fv;
		tick_data_t data;
		logic       fixed;
		result_t    res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	// Model copy of the configuration and the controller state.
	logic signed [GAIN_W-1:0]       gain_p;
	logic signed [GAIN_W-1:0]       gain_d;
	mode_t                          cur_mode;
	logic signed [FRAME_BYTE_W-1:0] ref_speed_a;
	logic signed [FRAME_BYTE_W-1:0] ref_speed_b;
	logic                           turn_neg;
	int                             drive_a;
	int                             drive_b;
	longint                         last_err_a;
	longint                         last_err_b;

	result_t pending_results[$];
	row_t    rows[$];
	int      fail_count;
	int      report_count;
	int      cycle_count;
	logic    quiet;

	dual_motor_speed_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t res_of(int pa, logic da, int pb, logic db, mode_t md);
		result_t r;
		r = '0;
		r.pwm_a = pa[DUTY_W-1:0];
		r.dir_a = da;
		r.pwm_b = pb[DUTY_W-1:0];
		r.dir_b = db;
		r.mode_now = md;
		return r;
	endfunction

	function automatic row_t mk_row(logic fv, logic signed [7:0] op, logic signed [7:0] sa,
			logic signed [7:0] sb, logic signed [7:0] ang, logic signed [15:0] ea,
			logic signed [15:0] eb);
		row_t r;
		r = '0;
		r.fv = fv;
		r.data.frame_op = op;
		r.data.frame_speed_a = sa;
		r.data.frame_speed_b = sb;
		r.data.frame_angle = ang;
		r.data.enc_count_a = ea;
		r.data.enc_count_b = eb;
		return r;
	endfunction

	function automatic row_t with_res(row_t r, result_t res);
		r.fixed = 1'b1;
		r.res = res;
		return r;
	endfunction

	// Duty and direction of one channel from a signed motor value.
	function automatic void encode_channel(int v, output logic [DUTY_W-1:0] duty,
			output logic dir);
		int raw;
		if (v > 0) begin
			dir = 1'b0;
			raw = v;
		end else if (v == 0) begin
			dir = 1'b1;
			raw = DUTY_FULL;
		end else begin
			dir = 1'b1;
			raw = 0;
		end
		duty = raw[DUTY_W-1:0];
	endfunction

	// Incremental PI step, exact in 64 bits, clamped to the duty range.
	function automatic void pi_update(int count, int target, inout int drive,
			inout longint last_err);
		longint err;
		longint acc;
		err = longint'(target) - longint'(count) * ERROR_SCALE;
		acc = longint'(drive) + longint'(gain_p) * err + longint'(gain_d) * (err - last_err);
		if (acc > DUTY_FULL)
			acc = DUTY_FULL;
		if (acc < 0)
			acc = 0;
		drive = int'(acc);
		last_err = err;
	endfunction

	function automatic void predict_tick(logic fv, tick_data_t d, output result_t r);
		int ang;
		int op;
		int motor_a;
		int motor_b;
		ang = int'($signed(d.frame_angle));
		op = int'($signed(d.frame_op));
		if (fv) begin
			if (ang != 0) begin
				turn_neg = (ang < 0);
				cur_mode = MODE_TURN;
			end else if (op == int'(OP_SPEED) || op == int'(OP_SPEED_ALT)) begin
				ref_speed_a = d.frame_speed_a;
				ref_speed_b = d.frame_speed_b;
				cur_mode = MODE_SPEED;
			end else if (op == int'(OP_HALT)) begin
				cur_mode = MODE_HALT;
			end else begin
				// An unknown opcode behaves as a speed frame with zero targets.
				ref_speed_a = '0;
				ref_speed_b = '0;
				cur_mode = MODE_SPEED;
			end
		end
		case (cur_mode)
			MODE_SPEED: begin
				pi_update(int'($signed(d.enc_count_a)), int'(ref_speed_a), drive_a,
					last_err_a);
				pi_update(int'($signed(d.enc_count_b)), int'(ref_speed_b), drive_b,
					last_err_b);
				motor_a = drive_a;
				motor_b = drive_b;
			end
			MODE_HALT: begin
				motor_a = -1;
				motor_b = -1;
			end
			MODE_TURN: begin
				motor_a = turn_neg ? int'(TURN_DRIVE) : -1;
				motor_b = turn_neg ? -1 : int'(TURN_DRIVE);
			end
			default: begin
				motor_a = 0;
				motor_b = 0;
			end
		endcase
		r = '0;
		encode_channel(motor_b, r.pwm_a, r.dir_a);
		encode_channel(motor_a, r.pwm_b, r.dir_b);
		r.mode_now = cur_mode;
	endfunction

	function automatic void note_field(string name, longint want, longint got);
		if (want != got) begin
			fail_count++;
			if (report_count < MAX_REPORTS) begin
				report_count++;
				$display("mismatch %s: expected %0d, actual %0d", name, want, got);
			end
		end
	endfunction

	// Result side: stall at random and check each result transaction.
	always @(negedge clk)
		m_tready <= quiet || ($urandom_range(0, 99) >= 10);

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				fail_count++;
				if (report_count < MAX_REPORTS) begin
					report_count++;
					$display("unexpected result transaction %h", m_tdata);
				end
			end else begin
				want = pending_results.pop_front();
				note_field("pwm_a", want.pwm_a, got.pwm_a);
				note_field("dir_a", want.dir_a, got.dir_a);
				note_field("pwm_b", want.pwm_b, got.pwm_b);
				note_field("dir_b", want.dir_b, got.dir_b);
				note_field("mode_now", want.mode_now, got.mode_now);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// One APB transfer, setup then access, then back to idle; returns read data
	// on a read.
	task automatic apb_xfer(logic wr, logic [2:0] addr, logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_gain(logic idx, int value);
		logic signed [GAIN_W-1:0] g;
		logic [31:0] rd;
		g = value[GAIN_W-1:0];
		apb_xfer(1'b1, {idx, 2'b00}, {{16{g[GAIN_W-1]}}, g}, rd);
		if (idx == REG_PGAIN)
			gain_p = g;
		else
			gain_d = g;
		apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
		note_field("gain readback", g, $signed(rd[GAIN_W-1:0]));
	endtask

	// Offer one tick with random gaps before it; predict once it is accepted.
	task automatic send_tick(logic fv, tick_data_t d, logic fixed, result_t res);
		result_t predicted;
		while (!quiet && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= fv;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_tick(fv, d, predicted);
		pending_results.push_back(fixed ? res : predicted);
		@(negedge clk);
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_count();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return 16'(int'($urandom_range(0, 6)) - 3);
		else if (pick < 75)
			return 16'(int'($urandom_range(0, 400)) - 200);
		return 16'($urandom);
	endfunction

	// Mostly speed frames among plain ticks, with halt, turn and junk frames mixed in.
	function automatic void gen_tick(output logic fv, output tick_data_t d);
		int kind;
		d = {$urandom, $urandom};
		d.enc_count_a = rand_count();
		d.enc_count_b = rand_count();
		fv = ($urandom_range(0, 99) < 25);
		if (fv) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				d.frame_op = $urandom_range(0, 1) ? OP_SPEED_ALT : OP_SPEED;
				d.frame_angle = '0;
				if ($urandom_range(0, 1)) begin
					d.frame_speed_a = 8'(int'($urandom_range(0, 40)) - 20);
					d.frame_speed_b = 8'(int'($urandom_range(0, 40)) - 20);
				end
			end else if (kind < 72) begin
				d.frame_op = OP_HALT;
				d.frame_angle = '0;
			end else if (kind < 84) begin
				while (d.frame_angle == '0)
					d.frame_angle = 8'($urandom);
			end
		end
	endfunction

	initial begin
		result_t res_idle;
		result_t res_halt;
		result_t res_turn_pos;
		result_t res_turn_neg;
		row_t r;
		logic fv;
		tick_data_t d;
		int gp;
		int gd;

		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		quiet = 1'b0;
		fail_count = 0;
		report_count = 0;
		cycle_count = 0;
		gain_p = '0;
		gain_d = '0;
		cur_mode = MODE_IDLE;
		ref_speed_a = '0;
		ref_speed_b = '0;
		turn_neg = 1'b0;
		drive_a = 0;
		drive_b = 0;
		last_err_a = 0;
		last_err_b = 0;

		res_idle = res_of(DUTY_FULL, 1'b1, DUTY_FULL, 1'b1, MODE_IDLE);
		res_halt = res_of(0, 1'b1, 0, 1'b1, MODE_HALT);
		res_turn_pos = res_of(int'(TURN_DRIVE), 1'b0, 0, 1'b1, MODE_TURN);
		res_turn_neg = res_of(0, 1'b1, int'(TURN_DRIVE), 1'b0, MODE_TURN);

		// Idle ignores the encoders, even at their extremes.
		rows.push_back(with_res(mk_row(0, 0, 0, 0, 0, -32768, 32767), res_idle));
		rows.push_back(with_res(mk_row(1, OP_HALT, 0, 0, 0, 5, 5), res_halt));
		rows.push_back(with_res(mk_row(1, OP_SPEED, 9, 9, 1, 0, 0), res_turn_pos));
		rows.push_back(with_res(mk_row(1, OP_HALT, 0, 0, -128, 0, 0), res_turn_neg));
		// A nonzero angle wins over the opcode.
		rows.push_back(with_res(mk_row(1, OP_SPEED, 127, 127, 127, 0, 0), res_turn_pos));
		rows.push_back(with_res(mk_row(0, 0, 0, 0, 0, 32767, -32768), res_turn_pos));
		rows.push_back(mk_row(1, OP_SPEED, 127, -128, 0, 0, 0));
		rows.push_back(mk_row(0, 0, 0, 0, 0, -32768, 32767));
		rows.push_back(mk_row(0, 0, 0, 0, 0, 32767, -32768));
		rows.push_back(mk_row(1, OP_SPEED_ALT, -128, 127, 0, 0, 0));
		// Halt keeps the targets; the PI state holds until speed mode returns.
		rows.push_back(with_res(mk_row(1, OP_HALT, 55, -55, 0, 1, 1), res_halt));
		rows.push_back(with_res(mk_row(0, 0, 0, 0, 0, 300, -300), res_halt));
		rows.push_back(with_res(mk_row(0, OP_SPEED, 1, 1, 0, 2, 2), res_halt));
		// Unknown opcodes with a zero angle select speed mode with zero targets.
		rows.push_back(mk_row(1, 8'sd3, 100, 100, 0, 1, -1));
		rows.push_back(mk_row(1, -128, -1, -1, 0, -2, 2));
		rows.push_back(mk_row(1, 127, 50, 50, 0, 0, 0));
		rows.push_back(mk_row(1, OP_SPEED_ALT, 10, -10, 0, 1, -1));
		rows.push_back(mk_row(0, -1, -1, -1, 0, 0, 0));
		rows.push_back(with_res(mk_row(1, OP_SPEED, 0, 0, -1, 0, 0), res_turn_neg));
		rows.push_back(mk_row(1, OP_SPEED, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(0, 0, 0, 0, 0, -1, 1));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_gain(REG_PGAIN, 2);
		write_gain(REG_DGAIN, 1);
		foreach (rows[i]) begin
			r = rows[i];
			send_tick(r.fv, r.data, r.fixed, r.res);
		end
		wait_results();

		// Each phase runs under its own gains, written only once the pipe is empty.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin gp = 0; gd = 0; end
				1: begin gp = 1; gd = 0; end
				2: begin
					gp = int'($urandom_range(0, 16)) - 8;
					gd = int'($urandom_range(0, 16)) - 8;
				end
				3: begin gp = 32767; gd = 32767; end
				4: begin gp = -32768; gd = -32768; end
				5: begin gp = 32767; gd = -32768; end
				6: begin gp = -32768; gd = 32767; end
				default: begin
					gp = int'($urandom_range(0, 65535)) - 32768;
					gd = int'($urandom_range(0, 65535)) - 32768;
				end
			endcase
			if ($urandom_range(0, 1)) begin
				write_gain(REG_PGAIN, gp);
				write_gain(REG_DGAIN, gd);
			end else begin
				write_gain(REG_DGAIN, gd);
				write_gain(REG_PGAIN, gp);
			end
			// One phase runs with neither side pausing.
			quiet = (ph == 2);
			for (int n = 0; n < PHASE_TICKS; n++) begin
				gen_tick(fv, d);
				send_tick(fv, d, 1'b0, '0);
			end
			wait_results();
			quiet = 1'b0;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
design/dmsc_pkg.sv
design/dual_motor_speed_controller.sv
sim/tb_top.sv
